// ===== hdl/rppf_pkg.sv =====
// ----------------------------------------------------------------------------
// rppf_pkg
// Shared constants, types and the controller/datapath interface for the
// page-table region pattern prefetcher.
// ----------------------------------------------------------------------------
package rppf_pkg;

  localparam int unsigned ADDR_W         = 64;
  localparam int unsigned REGION_ENTRIES = 128;
  localparam int unsigned MAX_STRIDE     = 256;
  localparam int unsigned DEGREE         = 2;
  localparam int unsigned PAGE_SHIFT     = 12;
  localparam int unsigned LINE_SHIFT     = 6;
  localparam int unsigned PTE_SHIFT      = 3;

  // region key / offset layout
  localparam int unsigned KEY_SHIFT = 2 * PAGE_SHIFT - PTE_SHIFT;
  localparam int unsigned TAG_W     = ADDR_W - KEY_SHIFT;
  localparam int unsigned OFF_W     = PAGE_SHIFT - PTE_SHIFT;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_W     = 6;
  localparam int unsigned WRD_W     = OFF_W - BIT_W;
  localparam int unsigned ENT_W     = $clog2(REGION_ENTRIES);
  localparam int unsigned RAM_AW    = ENT_W + WRD_W;
  localparam int unsigned RAM_DEPTH = REGION_ENTRIES << WRD_W;

  // line-stride group: aligned run of page bits tested as one
  localparam int unsigned GRP_SHIFT = (PAGE_SHIFT > LINE_SHIFT + PTE_SHIFT) ?
                                      PAGE_SHIFT - LINE_SHIFT - PTE_SHIFT : 0;
  localparam int unsigned GRP       = 1 << GRP_SHIFT;
  localparam logic [WORD_BITS-1:0] GRP_MASK = WORD_BITS'((65'd1 << GRP) - 65'd1);

  // strides
  localparam int unsigned PAGE_STRIDE = 1 << PAGE_SHIFT;
  localparam int unsigned LINE_STRIDE = PAGE_STRIDE + (1 << LINE_SHIFT);
  localparam int unsigned D_W   = $clog2(MAX_STRIDE * LINE_STRIDE + 1) + 1;
  localparam int unsigned I_W   = $clog2(MAX_STRIDE + 1);
  localparam int unsigned ISS_W = $clog2(DEGREE + 1);

  typedef enum logic [1:0] {
    SEL_A,   // demand address
    SEL_M,   // one stride behind
    SEL_M2,  // two strides behind
    SEL_P    // candidate
  } probe_sel_t;

  typedef struct packed {
    logic       load_a;
    logic       cmp;
    probe_sel_t sel;
    logic       rd;
    logic       wr_acc;
    logic       wr_pf;
    logic       alloc;
    logic       clr_all;
    logic       clr_ent;
    logic       scan_init;
    logic       step;
    logic       emit;
    logic       flush;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic tacc;
    logic tpf;
    logic samepg;
    logic pass;
    logic scan_end;
    logic clr_done_all;
    logic clr_done_ent;
    logic emit_ok;
    logic held_v;
  } dp_sts_t;

endpackage

// ===== hdl/pte_region_pattern_prefetcher_top.sv =====
// ----------------------------------------------------------------------------
// pte_region_pattern_prefetcher_top
// Region access-map pattern prefetcher over page-table-page regions.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------
//   in_     | in  | in_tvalid / in_tready  | tdata: demand_address
//   out_    | out | out_tvalid / out_tready| tdata: prefetch_address,
//           |     |                        | tuser: fill_this_level,
//           |     |                        | tlast: last_of_run
//
// One item at a time. Every region lookup runs tag compare, priority encode
// + bitmap RAM read, then test; a stride step may also allocate and clear
// the candidate's region when it misses on the page-stride pass.
// A region miss on demand allocates and clears an entry; a hit scans up to
// 4 x 256 strides. After reset the bitmap RAMs are swept clear, in_tready low.
// A stalled output only holds the scan at its next emitted item or the final flush.
// ----------------------------------------------------------------------------
module pte_region_pattern_prefetcher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [63:0] demand_address
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [63:0] prefetch_address
  output logic        out_tuser,   // [0] fill_this_level
  output logic        out_tlast
);
  import rppf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rppf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rppf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_addr   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_addr  (out_tdata),
    .out_fill  (out_tuser),
    .out_last  (out_tlast)
  );

`ifndef ASSERT_OFF
  // bitmap RAM port is used by one operation at a time
  a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rd, cmd.wr_acc, cmd.wr_pf, cmd.clr_all, cmd.clr_ent}))
    else $error("bitmap RAM port conflict");

  // no result left behind when a new item may enter
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sts.held_v)
    else $error("held result pending while idle");

  // access bit set only on a region hit
  a_acc_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_acc |-> sts.hit)
    else $error("access bit write without region hit");
`endif

endmodule

// ===== hdl/rppf_ram.sv =====
// ----------------------------------------------------------------------------
// rppf_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module rppf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hdl/rppf_dp.sv =====
// ----------------------------------------------------------------------------
// rppf_dp
// Datapath: region tags, FIFO victim pointer, bitmap RAMs, stride
// accumulators, probe lookup and the held/output result registers.
// ----------------------------------------------------------------------------
module rppf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rppf_pkg::ADDR_W-1:0]  in_addr,
  input  rppf_pkg::dp_cmd_t            cmd,
  output rppf_pkg::dp_sts_t            sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [rppf_pkg::ADDR_W-1:0]  out_addr,
  output logic                         out_fill,
  output logic                         out_last
);
  import rppf_pkg::*;

  logic [ADDR_W-1:0]         a_r;
  logic [D_W-1:0]            d_r;
  logic [I_W-1:0]            i_r;
  logic [ISS_W-1:0]          iss_r;
  logic                      pass_r;
  logic                      dir_r;
  logic [ADDR_W-1:0]         probe_r;
  logic [REGION_ENTRIES-1:0] match_r;
  logic                      hit_r;
  logic [ENT_W-1:0]          idx_r;
  logic [ENT_W-1:0]          victim_r;
  logic [RAM_AW-1:0]         ccnt_r;
  logic [TAG_W-1:0]          tag_r [REGION_ENTRIES];
  logic                      held_v_r;
  logic [ADDR_W-1:0]         held_addr_r;
  logic                      held_fill_r;
  logic                      out_v_r;
  logic [ADDR_W-1:0]         out_addr_r;
  logic                      out_fill_r;
  logic                      out_last_r;

  logic [ADDR_W-1:0]    operand;
  logic                 sub;
  logic [ADDR_W-1:0]    probe_nxt;
  logic [TAG_W-1:0]     probe_key;
  logic [ENT_W-1:0]     enc_idx;
  logic [OFF_W-1:0]     off;
  logic [WRD_W-1:0]     word;
  logic [BIT_W-1:0]     bpos;
  logic [WORD_BITS-1:0] bit_mask;
  logic [WORD_BITS-1:0] tmask;
  logic [RAM_AW-1:0]    ram_addr;
  logic                 acc_we;
  logic                 pf_we;
  logic [WORD_BITS-1:0] acc_wdata;
  logic [WORD_BITS-1:0] pf_wdata;
  logic [WORD_BITS-1:0] acc_rdata;
  logic [WORD_BITS-1:0] pf_rdata;
  logic                 dir_done;
  logic [D_W-1:0]       stride;

  // probe address: a, or a +/- d or 2d
  always_comb begin
    case (cmd.sel)
      SEL_A:   operand = '0;
      SEL_M2:  operand = ADDR_W'(d_r) << 1;
      default: operand = ADDR_W'(d_r);
    endcase
    sub       = (cmd.sel == SEL_P) ? dir_r : ~dir_r;
    probe_nxt = sub ? a_r - operand : a_r + operand;
    probe_key = probe_nxt[ADDR_W-1:KEY_SHIFT];
  end

  // lowest matching entry wins
  always_comb begin
    enc_idx = '0;
    for (int e = REGION_ENTRIES - 1; e >= 0; e--) begin
      if (match_r[e]) begin
        enc_idx = ENT_W'(e);
      end
    end
  end

  assign off      = probe_r[PAGE_SHIFT +: OFF_W];
  assign word     = off[OFF_W-1:BIT_W];
  assign bpos     = off[BIT_W-1:0];
  assign bit_mask = WORD_BITS'(1) << bpos;
  assign tmask    = pass_r ? (GRP_MASK << (bpos & ~BIT_W'(GRP - 1))) : bit_mask;

  always_comb begin
    if (cmd.rd) begin
      ram_addr = {enc_idx, word};
    end else if (cmd.clr_all) begin
      ram_addr = ccnt_r;
    end else if (cmd.clr_ent) begin
      ram_addr = {idx_r, ccnt_r[WRD_W-1:0]};
    end else begin
      ram_addr = {idx_r, word};
    end
  end

  assign acc_we    = cmd.wr_acc | cmd.clr_all | cmd.clr_ent;
  assign pf_we     = cmd.wr_pf | cmd.clr_all | cmd.clr_ent;
  assign acc_wdata = cmd.wr_acc ? (acc_rdata | bit_mask) : '0;
  assign pf_wdata  = cmd.wr_pf ? ((hit_r ? pf_rdata : '0) | bit_mask) : '0;

  rppf_ram #(.WIDTH(WORD_BITS), .DEPTH(RAM_DEPTH)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .re    (cmd.rd),
    .addr  (ram_addr),
    .wdata (acc_wdata),
    .rdata (acc_rdata)
  );

  rppf_ram #(.WIDTH(WORD_BITS), .DEPTH(RAM_DEPTH)) u_pf_ram (
    .clk   (clk),
    .we    (pf_we),
    .re    (cmd.rd),
    .addr  (ram_addr),
    .wdata (pf_wdata),
    .rdata (pf_rdata)
  );

  assign dir_done = (iss_r == ISS_W'(DEGREE)) || (i_r == I_W'(MAX_STRIDE));
  assign stride   = pass_r ? D_W'(LINE_STRIDE) : D_W'(PAGE_STRIDE);

  always_comb begin
    sts.hit          = hit_r;
    sts.tacc         = hit_r && (|(acc_rdata & tmask));
    sts.tpf          = hit_r && (|(pf_rdata & tmask));
    sts.samepg       = probe_r[ADDR_W-1:PAGE_SHIFT] == a_r[ADDR_W-1:PAGE_SHIFT];
    sts.pass         = pass_r;
    sts.scan_end     = dir_done & dir_r & pass_r;
    sts.clr_done_all = ccnt_r == RAM_AW'(RAM_DEPTH - 1);
    sts.clr_done_ent = &ccnt_r[WRD_W-1:0];
    sts.emit_ok      = !held_v_r || !out_v_r || out_ready;
    sts.held_v       = held_v_r;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_r <= in_addr;
    end
    if (cmd.cmp) begin
      probe_r <= probe_nxt;
      for (int e = 0; e < REGION_ENTRIES; e++) begin
        match_r[e] <= tag_r[e] == probe_key;
      end
    end
    if (cmd.emit) begin
      held_addr_r <= probe_r;
      held_fill_r <= ~pass_r;
    end
    if ((cmd.emit && held_v_r) || cmd.flush) begin
      out_addr_r <= held_addr_r;
      out_fill_r <= held_fill_r;
      out_last_r <= cmd.flush;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r      <= '0;
      i_r      <= '0;
      iss_r    <= '0;
      pass_r   <= 1'b0;
      dir_r    <= 1'b0;
      hit_r    <= 1'b0;
      idx_r    <= '0;
      victim_r <= '0;
      ccnt_r   <= '0;
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int e = 0; e < REGION_ENTRIES; e++) begin
        tag_r[e] <= '0;
      end
    end else begin
      if (cmd.load_a) begin
        pass_r <= 1'b0;
        dir_r  <= 1'b0;
      end
      if (cmd.rd) begin
        hit_r <= |match_r;
        idx_r <= enc_idx;
      end
      if (cmd.alloc) begin
        tag_r[victim_r] <= probe_r[ADDR_W-1:KEY_SHIFT];
        idx_r           <= victim_r;
        hit_r           <= 1'b0;
        ccnt_r          <= '0;
        victim_r        <= (victim_r == ENT_W'(REGION_ENTRIES - 1)) ? '0 : victim_r + 1'b1;
      end
      if (cmd.clr_all || cmd.clr_ent) begin
        ccnt_r <= ccnt_r + 1'b1;
      end
      if (cmd.scan_init) begin
        pass_r <= 1'b0;
        dir_r  <= 1'b0;
        i_r    <= I_W'(1);
        d_r    <= D_W'(PAGE_STRIDE);
        iss_r  <= '0;
      end
      if (cmd.step) begin
        if (dir_done) begin
          if (!dir_r) begin
            dir_r <= 1'b1;
            i_r   <= I_W'(1);
            d_r   <= stride;
            iss_r <= '0;
          end else if (!pass_r) begin
            pass_r <= 1'b1;
            dir_r  <= 1'b0;
            i_r    <= I_W'(1);
            d_r    <= D_W'(LINE_STRIDE);
            iss_r  <= '0;
          end
        end else begin
          i_r <= i_r + 1'b1;
          d_r <= d_r + stride;
        end
      end
      if (cmd.emit) begin
        iss_r    <= iss_r + 1'b1;
        held_v_r <= 1'b1;
      end
      if (cmd.flush) begin
        held_v_r <= 1'b0;
      end
      if ((cmd.emit && held_v_r) || cmd.flush) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_addr  = out_addr_r;
  assign out_fill  = out_fill_r;
  assign out_last  = out_last_r;

endmodule

// ===== hdl/rppf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rppf_ctrl
// Sequencer: demand lookup, allocation, stride scan and result flush.
// ----------------------------------------------------------------------------
module rppf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  rppf_pkg::dp_sts_t  sts,
  output rppf_pkg::dp_cmd_t  cmd
);
  import rppf_pkg::*;

  typedef enum logic [4:0] {
    ST_CLR_ALL, ST_IDLE,
    ST_A_CMP, ST_A_RD, ST_A_TST, ST_D_ALLOC, ST_D_CLR,
    ST_M_CMP, ST_M_RD, ST_M_TST,
    ST_M2_CMP, ST_M2_RD, ST_M2_TST,
    ST_P_CMP, ST_P_RD, ST_P_TST,
    ST_EMIT, ST_P_ALLOC, ST_P_CLR, ST_MARK, ST_NEXT, ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR_ALL;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_A;
    state_nxt = state_r;
    case (state_r)
      ST_CLR_ALL: begin
        cmd.clr_all = 1'b1;
        if (sts.clr_done_all) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_a = 1'b1;
          state_nxt  = ST_A_CMP;
        end
      end
      ST_A_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = ST_A_RD;
      end
      ST_A_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_A_TST;
      end
      ST_A_TST: begin
        if (sts.hit) begin
          cmd.wr_acc    = 1'b1;
          cmd.scan_init = 1'b1;
          state_nxt     = ST_M_CMP;
        end else begin
          state_nxt = ST_D_ALLOC;
        end
      end
      ST_D_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = ST_D_CLR;
      end
      ST_D_CLR: begin
        cmd.clr_ent = 1'b1;
        if (sts.clr_done_ent) state_nxt = ST_IDLE;
      end
      ST_M_CMP: begin
        cmd.cmp   = 1'b1;
        cmd.sel   = SEL_M;
        state_nxt = ST_M_RD;
      end
      ST_M_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_M_TST;
      end
      ST_M_TST: begin
        state_nxt = sts.tacc ? ST_M2_CMP : ST_NEXT;
      end
      ST_M2_CMP: begin
        cmd.cmp   = 1'b1;
        cmd.sel   = SEL_M2;
        state_nxt = ST_M2_RD;
      end
      ST_M2_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_M2_TST;
      end
      ST_M2_TST: begin
        state_nxt = sts.tacc ? ST_P_CMP : ST_NEXT;
      end
      ST_P_CMP: begin
        cmd.cmp   = 1'b1;
        cmd.sel   = SEL_P;
        state_nxt = ST_P_RD;
      end
      ST_P_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_P_TST;
      end
      ST_P_TST: begin
        state_nxt = (!sts.tacc && !sts.tpf && !sts.samepg) ? ST_EMIT : ST_NEXT;
      end
      ST_EMIT: begin
        if (sts.emit_ok) begin
          cmd.emit = 1'b1;
          if (sts.pass) begin
            state_nxt = ST_NEXT;
          end else begin
            state_nxt = sts.hit ? ST_MARK : ST_P_ALLOC;
          end
        end
      end
      ST_P_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = ST_P_CLR;
      end
      ST_P_CLR: begin
        cmd.clr_ent = 1'b1;
        if (sts.clr_done_ent) state_nxt = ST_MARK;
      end
      ST_MARK: begin
        cmd.wr_pf = 1'b1;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.step  = 1'b1;
        state_nxt = sts.scan_end ? ST_FLUSH : ST_M_CMP;
      end
      ST_FLUSH: begin
        if (!sts.held_v) begin
          state_nxt = ST_IDLE;
        end else if (sts.emit_ok) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== bench/tb_pte_region_pattern_prefetcher_top.sv =====
// ----------------------------------------------------------------------------
// tb_pte_region_pattern_prefetcher_top
// Self-checking bench for the page-table region pattern prefetcher. Demand
// addresses are streamed in. A behavioral copy of the region table predicts
// every prefetch item, in order, and each output item is compared field by
// field. The bench runs directed stride patterns, address-wrap extremes, and
// random stride runs over a small pool of regions mixed with random noise.
// Both sides idle in short random bursts until the last part of the run.
// ----------------------------------------------------------------------------
module tb_pte_region_pattern_prefetcher_top;
  import rppf_pkg::*;

  // Slowest correct run: a hit that reaches the candidate test at every stride
  // is 1024 steps, plus at most four region allocations and eight emits, each
  // emit held by an output stall and an input gap. Sum this over 311 items,
  // add the clear sweep after reset, and take about five times that.
  localparam int unsigned CYCLE_LIMIT = 16_000_000;
  localparam int unsigned POOL_N      = 8;

  typedef struct packed {
    logic [63:0] addr;
    logic        fill;  // page stride
    logic        last;
  } prefetch_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // [63:0] demand_address
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;   // [63:0] prefetch_address
  logic        out_tuser;   // [0] fill_this_level
  logic        out_tlast;

  pte_region_pattern_prefetcher_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Shadow region table.
  logic [TAG_W-1:0]        region_key_q [REGION_ENTRIES];
  logic [(1<<OFF_W)-1:0]   touched_map  [REGION_ENTRIES];
  logic [(1<<OFF_W)-1:0]   fetched_map  [REGION_ENTRIES];
  longint unsigned         alloc_stamp  [REGION_ENTRIES];
  longint unsigned         next_stamp;

  prefetch_t   pending_pf[$];
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned pf_seen;
  int unsigned region_misses;
  bit          noisy;          // idle bursts enabled
  int unsigned ready_hold;
  logic [TAG_W-1:0] pool_key[POOL_N];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Global watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d prefetches still due", cycle_cnt,
               pending_pf.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---- predictor --------------------------------------------------------
  function automatic logic [TAG_W-1:0] key_of(logic [63:0] a);
    return a[63:KEY_SHIFT];
  endfunction

  function automatic logic [OFF_W-1:0] page_of(logic [63:0] a);
    return a[PAGE_SHIFT +: OFF_W];
  endfunction

  // lowest index with a matching key wins
  function automatic int lookup_region(logic [TAG_W-1:0] k);
    for (int e = 0; e < REGION_ENTRIES; e++)
      if (region_key_q[e] == k) return e;
    return -1;
  endfunction

  // FIFO replacement: oldest stamp, lowest index on a tie
  function automatic int replace_region(logic [TAG_W-1:0] k);
    int oldest;
    oldest = 0;
    for (int e = 1; e < REGION_ENTRIES; e++)
      if (alloc_stamp[e] < alloc_stamp[oldest]) oldest = e;
    region_key_q[oldest] = k;
    touched_map[oldest]  = '0;
    fetched_map[oldest]  = '0;
    alloc_stamp[oldest]  = next_stamp;
    next_stamp++;
    return oldest;
  endfunction

  function automatic bit page_marked(bit pf_map, logic [63:0] a);
    int e;
    e = lookup_region(key_of(a));
    if (e < 0) return 1'b0;
    return pf_map ? fetched_map[e][page_of(a)] : touched_map[e][page_of(a)];
  endfunction

  // line-stride test: any page set in the aligned group
  function automatic bit group_marked(bit pf_map, logic [63:0] a);
    int e;
    int unsigned base;
    e = lookup_region(key_of(a));
    if (e < 0) return 1'b0;
    base = (page_of(a) >> GRP_SHIFT) << GRP_SHIFT;
    for (int unsigned k = 0; k < GRP; k++)
      if (pf_map ? fetched_map[e][base+k] : touched_map[e][base+k]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic predict_prefetches(input logic [63:0] a);
    int          e;
    int          issued;
    int          n;
    logic [63:0] step_len, d, p, m, m2;
    bit          hit;
    prefetch_t   pf;
    n = 0;
    e = lookup_region(key_of(a));
    if (e < 0) begin
      void'(replace_region(key_of(a)));
      region_misses++;
      return;
    end
    touched_map[e][page_of(a)] = 1'b1;
    for (int pass = 0; pass < 2; pass++) begin
      step_len = (pass == 0) ? 64'(PAGE_STRIDE) : 64'(LINE_STRIDE);
      for (int dir = 0; dir < 2; dir++) begin
        issued = 0;
        for (int i = 1; i <= MAX_STRIDE && issued < DEGREE; i++) begin
          d  = step_len * 64'(i);
          p  = (dir == 0) ? a + d : a - d;
          m  = (dir == 0) ? a - d : a + d;
          m2 = (dir == 0) ? a - 2 * d : a + 2 * d;
          if (pass == 0)
            hit = page_marked(0, m) && page_marked(0, m2) && !page_marked(0, p)
                  && !page_marked(1, p);
          else
            hit = group_marked(0, m) && group_marked(0, m2) && !group_marked(0, p)
                  && !group_marked(1, p);
          if (!hit || a[63:PAGE_SHIFT] == p[63:PAGE_SHIFT]) continue;
          pf.addr = p;
          pf.fill = (pass == 0);
          pf.last = 1'b0;
          pending_pf.push_back(pf);
          n++;
          issued++;
          if (pass == 0) begin
            e = lookup_region(key_of(p));
            if (e < 0) e = replace_region(key_of(p));
            fetched_map[e][page_of(p)] = 1'b1;
          end
        end
      end
    end
    if (n > 0) pending_pf[pending_pf.size()-1].last = 1'b1;
  endtask

  // ---- stimulus side ------------------------------------------------------
  task automatic send_demand(input logic [63:0] a);
    in_tvalid <= 1'b1;
    in_tdata  <= a;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    predict_prefetches(a);
    if (noisy && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // ---- output side --------------------------------------------------------
  // random ready bursts while noisy
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (noisy && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    prefetch_t want;
    if (rst_n && out_tvalid && out_tready) begin
      pf_seen++;
      if (pending_pf.size() == 0) begin
        report_mismatch("unexpected item", out_tdata, '0);
      end else begin
        want = pending_pf.pop_front();
        if (out_tdata !== want.addr) report_mismatch("prefetch_address", out_tdata, want.addr);
        if (out_tuser !== want.fill) report_mismatch("fill_this_level", out_tuser, want.fill);
        if (out_tlast !== want.last) report_mismatch("last_of_run", out_tlast, want.last);
      end
    end
  end

  // ---- tests --------------------------------------------------------------
  // Key 0 hits entry 0 straight after reset; page strides up and down.
  task automatic test_page_strides();
    send_demand(64'h0);
    send_demand(64'h1000);
    send_demand(64'h2123);          // upward run -> 0x3123
    send_demand(64'h9000);
    send_demand(64'h8000);
    send_demand(64'h7fff);          // downward run -> 0x6fff
    send_demand(64'h3000);          // page already prefetched
  endtask

  // Page-plus-line strides, tested by page group.
  task automatic test_line_strides();
    send_demand(64'h10_0000);
    send_demand(64'h10_8200);
    send_demand(64'h11_0400);
    send_demand(64'h1f_0000);
    send_demand(64'h1e_7e00);
    send_demand(64'h1d_fc00);
  endtask

  // Top and bottom of the address space, wrap across 2^64, all-bit patterns.
  task automatic test_address_wrap();
    send_demand(64'hffff_ffff_ffff_ffff);   // region miss, allocates
    send_demand(64'hffff_ffff_ffff_dabc);
    send_demand(64'hffff_ffff_ffff_e000);
    send_demand(64'hffff_ffff_ffff_ffff);   // upward candidate wraps to 0
    send_demand(64'h5555_5555_5555_5555);
    send_demand(64'haaaa_aaaa_aaaa_aaaa);
    send_demand(64'h0000_0000_0000_1fff);
    send_demand(64'h0000_0000_0000_0fff);   // downward candidate wraps high
  endtask

  // Stride runs over a pool of regions, mixed with random noise that forces
  // replacement.
  task automatic test_random_patterns(input int unsigned n_items);
    int unsigned cnt, run_len, stride_pg;
    logic [63:0] a, step_len;
    for (int k = 0; k < POOL_N; k++) pool_key[k] = TAG_W'({$urandom, $urandom});
    pool_key[0] = '0;
    pool_key[1] = '1;
    cnt = 0;
    while (cnt < n_items) begin
      if (cnt > n_items * 4 / 5) noisy = 1'b0;
      if ($urandom_range(0, 9) < 3) begin
        send_demand({$urandom, $urandom});
        cnt++;
      end else begin
        if ($urandom_range(0, 7) == 0)
          pool_key[$urandom_range(0, POOL_N-1)] = TAG_W'({$urandom, $urandom});
        a = {pool_key[$urandom_range(0, POOL_N-1)], 21'($urandom)};
        case ($urandom_range(0, 3))
          0:       stride_pg = 1;
          1:       stride_pg = $urandom_range(2, 4);
          2:       stride_pg = $urandom_range(5, 300);
          default: stride_pg = 8;
        endcase
        step_len = ($urandom_range(0, 1) ? 64'(LINE_STRIDE) : 64'(PAGE_STRIDE))
                   * 64'(stride_pg);
        if ($urandom_range(0, 1)) step_len = -step_len;
        run_len = $urandom_range(3, 6);
        for (int j = 0; j < run_len && cnt < n_items; j++) begin
          send_demand(a);
          a = a + step_len;
          cnt++;
        end
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b1;
    cycle_cnt     = 0;
    err_cnt       = 0;
    items_sent    = 0;
    pf_seen       = 0;
    region_misses = 0;
    ready_hold    = 0;
    noisy         = 1'b1;
    for (int e = 0; e < REGION_ENTRIES; e++) begin
      region_key_q[e] = '0;
      touched_map[e]  = '0;
      fetched_map[e]  = '0;
      alloc_stamp[e]  = e;
    end
    next_stamp = REGION_ENTRIES;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_page_strides();
    test_line_strides();
    test_address_wrap();
    test_random_patterns(290);
    in_tvalid <= 1'b0;

    // drain: all predicted items out and the scan finished
    do @(posedge clk); while (pending_pf.size() != 0 || !in_tready);
    repeat (32) @(posedge clk);

    $display("sent %0d demand items (%0d region misses), checked %0d prefetch items",
             items_sent, region_misses, pf_seen);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
